/* hdl/a64se_pkg.sv */
// shared types, opcode codes and decode helpers for the a64 subset executor
// no dependencies
package a64se_pkg;

  localparam int unsigned MemBytes = 4096;
  localparam logic [63:0] ResetPc = 64'h0000_0000_0040_0000;

  typedef enum logic [4:0] {
    OP_NONE, OP_ADDS, OP_ADD, OP_SUBS, OP_ANDS, OP_EOR, OP_ORR, OP_MUL, OP_MOVZ,
    OP_HLT, OP_STUR, OP_LDUR, OP_ADDSI, OP_ADDI, OP_SUBSI, OP_SHIFT, OP_BR, OP_B,
    OP_BCOND, OP_CBZ, OP_CBNZ
  } op_t;

  // back end sequencing
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MEM, S_MUL, S_CLEAR
  } back_state_t;

  // decoded request passed from front to back
  typedef struct packed {
    op_t         op;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [63:0] imm;
    logic [5:0]  immr;
    logic        lsr;
    logic [3:0]  cond;
    logic [3:0]  nbytes;
  } dec_t;

  function automatic dec_t decode(input logic [31:0] w);
    dec_t d;
    logic [10:0] op11;
    logic [9:0]  op10;
    d = '0;
    op11 = w[31:21];
    op10 = w[31:22];
    d.rd = w[4:0];
    d.rn = w[9:5];
    d.rm = w[20:16];
    d.immr = w[21:16];
    d.lsr = (w[15:10] == 6'd63) || (w[15:10] == 6'd31);
    d.cond = w[3:0];
    d.imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
    d.nbytes = 4'd8;
    case (op11)
      11'h558: d.op = OP_ADDS;
      11'h458: d.op = OP_ADD;
      11'h758: d.op = OP_SUBS;
      11'h750: d.op = OP_ANDS;
      11'h650: d.op = OP_EOR;
      11'h550: d.op = OP_ORR;
      11'h4D8: d.op = OP_MUL;
      11'h694: begin d.op = OP_MOVZ; d.imm = {48'd0, w[20:5]}; end
      11'h6A2: d.op = OP_HLT;
      11'h7C0, 11'h3C0, 11'h1C0, 11'h7C2, 11'h3C2, 11'h1C2: begin
        d.op = op11[1] ? OP_LDUR : OP_STUR;
        d.imm = {{55{w[20]}}, w[20:12]};
        d.nbytes = (op11[10:9] == 2'b11) ? 4'd8 : (op11[9] ? 4'd2 : 4'd1);
      end
      default: begin
        if (op10[9:1] == 9'h162) d.op = OP_ADDSI;
        else if (op10[9:1] == 9'h122) d.op = OP_ADDI;
        else if (op10[9:1] == 9'h1E2) d.op = OP_SUBSI;
        else if (op10 == 10'h34D) d.op = OP_SHIFT;
        else if (w[31:10] == 22'h3587C0) d.op = OP_BR;
        else if (w[31:26] == 6'h05) begin
          d.op = OP_B;
          d.imm = {{36{w[25]}}, w[25:0], 2'b00};
        end else if (w[31:24] == 8'h54 || w[31:24] == 8'hB4 || w[31:24] == 8'hB5) begin
          d.op = (w[31:24] == 8'h54) ? OP_BCOND : (w[24] ? OP_CBNZ : OP_CBZ);
          d.imm = {{43{w[23]}}, w[23:5], 2'b00};
        end else d.op = OP_NONE;
      end
    endcase
    return d;
  endfunction

endpackage

/* hdl/a64se_front.sv */
// front: accepts instruction words, decodes them and holds them in a short queue
// depends on a64se_pkg
module a64se_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         instruction_word,
  output logic                q_valid,
  input  logic                q_ready,
  output a64se_pkg::dec_t     q_data
);

  localparam int unsigned Depth = 2;

  a64se_pkg::dec_t slots [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'(Depth));
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = slots[rd_ptr];

  // decoded entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= a64se_pkg::decode(instruction_word);
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1)) else $error("count did not grow");

endmodule

/* hdl/a64se_back.sv */
// back: executes decoded requests against registers, flags, pc and byte memory
// depends on a64se_pkg
module a64se_back #(
  parameter int unsigned MEMORY_BYTES = a64se_pkg::MemBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  a64se_pkg::dec_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     next_pc,
  output logic            recognized,
  output logic            halted,
  output logic            zero_flag,
  output logic            negative_flag,
  output logic            write_valid,
  output logic [4:0]      write_index,
  output logic [63:0]     write_value
);

  localparam int unsigned AddrW = $clog2(MEMORY_BYTES);
  localparam logic [3:0] MulLast = 4'd3;

  a64se_pkg::back_state_t state, state_next;
  a64se_pkg::dec_t cur;
  logic [63:0] regs [32];
  logic [31:0] reg_ok;
  logic [63:0] a, b, c;
  logic [63:0] pc;
  logic        fz, fn, hlt;
  logic [7:0]  mem [MEMORY_BYTES];
  logic [AddrW:0] clr_cnt;
  logic [63:0] addr;
  logic [3:0]  bi;
  logic [7:0]  rdata;
  logic [63:0] ldval;
  logic [63:0] prod;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic        res_full;

  // read ports for the register file; x31 and unwritten entries read zero
  always_ff @(posedge clk) begin
    if (state == a64se_pkg::S_READ) begin
      a <= reg_ok[cur.rn] ? regs[cur.rn] : 64'd0;
      b <= reg_ok[cur.rm] ? regs[cur.rm] : 64'd0;
      c <= reg_ok[cur.rd] ? regs[cur.rd] : 64'd0;
    end
  end

  // one 32x32 partial product a cycle: lo*lo, then lo*hi and hi*lo into the upper half
  always_comb begin
    case (bi[1:0])
      2'd0: begin mul_x = a[31:0]; mul_y = b[31:0]; end
      2'd1: begin mul_x = a[31:0]; mul_y = b[63:32]; end
      default: begin mul_x = a[63:32]; mul_y = b[31:0]; end
    endcase
    mul_p = {32'd0, mul_x} * {32'd0, mul_y};
  end

  logic [63:0] alu;
  logic        wr_en, setf, take, known;
  logic [63:0] pc_new;

  // execute datapath
  always_comb begin
    alu = 64'd0; wr_en = 1'b0; setf = 1'b0; take = 1'b0; known = 1'b1;
    pc_new = pc + 64'd4;
    case (cur.op)
      a64se_pkg::OP_ADDS:  begin alu = a + b; wr_en = 1'b1; setf = 1'b1; end
      a64se_pkg::OP_ADD:   begin alu = a + b; wr_en = 1'b1; end
      a64se_pkg::OP_SUBS:  begin alu = a - b; wr_en = 1'b1; setf = 1'b1; end
      a64se_pkg::OP_ANDS:  begin alu = a & b; wr_en = 1'b1; setf = 1'b1; end
      a64se_pkg::OP_EOR:   begin alu = a ^ b; wr_en = 1'b1; end
      a64se_pkg::OP_ORR:   begin alu = a | b; wr_en = 1'b1; end
      a64se_pkg::OP_MUL:   begin alu = prod; wr_en = 1'b1; end
      a64se_pkg::OP_MOVZ:  begin alu = cur.imm; wr_en = 1'b1; end
      a64se_pkg::OP_ADDSI: begin alu = a + cur.imm; wr_en = 1'b1; setf = 1'b1; end
      a64se_pkg::OP_ADDI:  begin alu = a + cur.imm; wr_en = 1'b1; end
      a64se_pkg::OP_SUBSI: begin alu = a - cur.imm; wr_en = 1'b1; setf = 1'b1; end
      a64se_pkg::OP_SHIFT: begin
        alu = cur.lsr ? (a >> cur.immr) : (a << (6'd0 - cur.immr));
        wr_en = 1'b1;
      end
      // last byte arrives in rdata on the final memory cycle
      a64se_pkg::OP_LDUR:  begin
        alu = ldval | ({56'd0, rdata} << {bi[2:0] - 3'd1, 3'b000});
        wr_en = 1'b1;
      end
      a64se_pkg::OP_BR:    pc_new = a;
      a64se_pkg::OP_B:     pc_new = pc + cur.imm;
      a64se_pkg::OP_BCOND: begin
        case (cur.cond)
          4'd0:  take = fz;
          4'd1:  take = !fz;
          4'd10: take = !fn;
          4'd11: take = fn;
          4'd12: take = !fz && !fn;
          4'd13: take = fz || fn;
          default: known = 1'b0;
        endcase
        pc_new = !known ? pc : (take ? pc + cur.imm : pc + 64'd4);
      end
      a64se_pkg::OP_CBZ:  pc_new = (c == 64'd0) ? pc + cur.imm : pc + 64'd4;
      a64se_pkg::OP_CBNZ: pc_new = (c != 64'd0) ? pc + cur.imm : pc + 64'd4;
      a64se_pkg::OP_NONE: pc_new = pc;
      default: ;
    endcase
    if (cur.rd == 5'd31) wr_en = 1'b0;
  end

  wire is_mem = (cur.op == a64se_pkg::OP_STUR) || (cur.op == a64se_pkg::OP_LDUR);
  wire is_mul = (cur.op == a64se_pkg::OP_MUL);
  wire long_op = !hlt && (is_mem || is_mul);
  wire [AddrW-1:0] maddr = addr[AddrW-1:0] + AddrW'(bi);
  wire [63:0] sdata = c >> {bi[2:0], 3'b000};

  // byte memory, one byte per cycle
  always_ff @(posedge clk) begin
    if (state == a64se_pkg::S_CLEAR) mem[clr_cnt[AddrW-1:0]] <= 8'd0;
    else if (state == a64se_pkg::S_MEM && cur.op == a64se_pkg::OP_STUR &&
             bi != cur.nbytes) mem[maddr] <= sdata[7:0];
    rdata <= mem[maddr];
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    case (state)
      a64se_pkg::S_CLEAR:
        if (clr_cnt == (AddrW+1)'(MEMORY_BYTES - 1)) state_next = a64se_pkg::S_IDLE;
      a64se_pkg::S_IDLE: begin
        q_ready = !res_full || out_ready;
        if (q_valid && q_ready) state_next = a64se_pkg::S_READ;
      end
      a64se_pkg::S_READ: state_next = a64se_pkg::S_EXEC;
      a64se_pkg::S_EXEC: begin
        if (!long_op) state_next = a64se_pkg::S_IDLE;
        else if (is_mem) state_next = a64se_pkg::S_MEM;
        else state_next = a64se_pkg::S_MUL;
      end
      a64se_pkg::S_MEM: if (bi == cur.nbytes) state_next = a64se_pkg::S_IDLE;
      a64se_pkg::S_MUL: if (bi == MulLast) state_next = a64se_pkg::S_IDLE;
      default: state_next = a64se_pkg::S_IDLE;
    endcase
  end

  wire finish = ((state == a64se_pkg::S_EXEC) && !long_op) ||
                ((state == a64se_pkg::S_MEM) && (bi == cur.nbytes)) ||
                ((state == a64se_pkg::S_MUL) && (bi == MulLast));
  wire commit_wr = !hlt && wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= a64se_pkg::S_CLEAR;
      clr_cnt <= '0;
      reg_ok <= '0;
      pc <= a64se_pkg::ResetPc;
      fz <= 1'b0; fn <= 1'b0; hlt <= 1'b0;
      res_full <= 1'b0;
      bi <= 4'd0;
    end else begin
      state <= state_next;
      if (state == a64se_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (q_valid && q_ready) cur <= q_data;
      if (finish) res_full <= 1'b1;
      else if (out_valid && out_ready) res_full <= 1'b0;
      if (state == a64se_pkg::S_EXEC) begin
        addr <= a + cur.imm;
        bi <= 4'd0;
        ldval <= 64'd0;
      end
      if (state == a64se_pkg::S_MEM) begin
        bi <= bi + 4'd1;
        if (bi != 4'd0) ldval <= ldval | ({56'd0, rdata} << {bi[2:0] - 3'd1, 3'b000});
      end
      // multiply accumulates three partial products
      if (state == a64se_pkg::S_MUL) begin
        bi <= bi + 4'd1;
        if (bi == 4'd0) prod <= mul_p;
        else if (bi != MulLast) prod <= prod + {mul_p[31:0], 32'd0};
      end
      if (finish) begin
        write_valid <= commit_wr;
        write_index <= commit_wr ? cur.rd : 5'd0;
        write_value <= commit_wr ? alu : 64'd0;
        recognized <= !hlt && (cur.op != a64se_pkg::OP_NONE);
        if (!hlt) begin
          pc <= pc_new;
          if (cur.op == a64se_pkg::OP_HLT) hlt <= 1'b1;
          if (setf) begin fz <= (alu == 64'd0); fn <= alu[63]; end
          if (wr_en) begin
            regs[cur.rd] <= alu;
            reg_ok[cur.rd] <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid = res_full;
  assign next_pc = pc;
  assign halted = hlt;
  assign zero_flag = fz;
  assign negative_flag = fn;

  a_x31_never: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> write_index != 5'd31) else $error("x31 written");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(hlt) && !$past(rst) |-> hlt) else $error("halt cleared");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != a64se_pkg::S_IDLE) |-> !q_ready) else $error("accept while busy");

endmodule

/* hdl/a64_subset_instruction_executor.sv */
// top level of the a64 subset executor: decode front, queue, execute back
// depends on a64se_pkg, a64se_front, a64se_back
//
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       instruction_word
// out       output     out_valid / out_ready     next_pc .. write_value
//
// alu and branch requests pass through a read and an execute state in the back end,
// multiply adds a multiply state (three 32x32 partial products), loads and stores
// a memory state (one byte of the memory port a cycle)
// after reset the byte memory is cleared before the back end takes any request
// the front queue holds two decoded requests; a pending result stalls only the back
module a64_subset_instruction_executor #(
  parameter int unsigned MEMORY_BYTES = a64se_pkg::MemBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] next_pc,
  output logic        recognized,
  output logic        halted,
  output logic        zero_flag,
  output logic        negative_flag,
  output logic        write_valid,
  output logic [4:0]  write_index,
  output logic [63:0] write_value
);

  logic            q_valid;
  logic            q_ready;
  a64se_pkg::dec_t q_data;

  a64se_front u_front (
    .clk, .rst, .in_valid, .in_ready, .instruction_word,
    .q_valid, .q_ready, .q_data
  );

  a64se_back #(.MEMORY_BYTES(MEMORY_BYTES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .next_pc, .recognized, .halted, .zero_flag,
    .negative_flag, .write_valid, .write_index, .write_value
  );

endmodule
